// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL; every check is clocked on i_clk
// and held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define AST_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/idq_pkg.sv
package idq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths of the stream items
    localparam int FUNC_W   = 3;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 4;
    localparam int STAT_W   = 2;
    localparam int OCNT_W   = 5;
    localparam int S_DATA_W = ((FUNC_W + VAL_W + POS_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((STAT_W + 3 * VAL_W + OCNT_W + 1 + 7) / 8) * 8;

    // Request codes
    localparam logic [FUNC_W-1:0] F_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] F_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] F_POP_BACK   = 3'd2;
    localparam logic [FUNC_W-1:0] F_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] F_REMOVE_AT  = 3'd4;
    localparam logic [FUNC_W-1:0] F_READ_AT    = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // Broadcast control for the cell row
    typedef struct packed {
        logic              push_front;
        logic              push_back;
        logic              pull;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

// File: rtl/idq_cell.sv
module idq_cell (
    input  logic                      i_clk,
    input  idq_pkg::t_cell_ctl        i_ctl,
    input  logic [idq_pkg::IDX_W-1:0] i_index,
    input  logic [idq_pkg::DATA_W-1:0] i_prev,
    input  logic [idq_pkg::DATA_W-1:0] i_next,
    output logic [idq_pkg::DATA_W-1:0] o_q
);
    import idq_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.push_front) begin
            // whole row moves one place toward the back
            n_data = i_prev;
        end else if (i_ctl.push_back && (CNT_W'(i_index) == i_ctl.count)) begin
            n_data = i_ctl.value;
        end else if (i_ctl.pull && (i_index >= i_ctl.pos)) begin
            // close the gap from the removed position onward
            n_data = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_q = r_data;

endmodule

// File: rtl/indexed_deque_top.sv
// Bounded double-ended queue of data handles built as a row of cells,
// cell k holding the entry at position k from the front.
// Input channel s_axis: one request per transaction (push back/front,
// pop back/front, remove at position, read at position).
// Output channel m_axis: exactly one result per request, carrying status,
// the popped/removed/read handle, and count, front, back and empty flag
// after the request.
// The result is registered and is valid in the cycle after the request is taken.
// Throughput: one request per cycle while the receiver takes results; every
// shifting cell loads from its neighbor in the same cycle, so removal at any position goes at the same rate.
// The result register is the only buffer: a new request is taken when it
// is empty or its result leaves in the same cycle. While the receiver
// stalls, the result holds and s_axis_tready stays low.
// Reset empties the queue and drops any pending result; entry contents
// are not cleared and are never read before written.
module indexed_deque_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // func[2:0], value_in[34:3], position[38:35], zero pad
    input  logic [idq_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // status[1:0], value_out[33:2], count[38:34], front_value[70:39],
    // back_value[102:71], is_empty[103]
    output logic [idq_pkg::M_DATA_W-1:0]   o_m_axis_tdata
);
    import idq_pkg::*;

    logic              w_acc;
    logic [FUNC_W-1:0] w_func;
    logic [VAL_W-1:0]  w_val;
    logic [POS_W-1:0]  w_pos;
    logic              w_full;
    logic              w_empty;
    logic              w_in_range;
    logic              w_push_req;
    logic [IDX_W-1:0]  w_back_idx;
    logic [IDX_W-1:0]  w_rd_idx;
    logic [DATA_W-1:0] w_rd_data;
    logic [DATA_W-1:0] w_back_data;
    logic [DATA_W-1:0] w_cell_q [DEPTH];
    logic              w_ok_read;
    t_cell_ctl         w_ctl;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic [VAL_W-1:0]  r_value;
    logic [VAL_W-1:0]  n_value;
    logic              r_out_valid;

    assign w_func = i_s_axis_tdata[FUNC_W-1:0];
    assign w_val  = i_s_axis_tdata[FUNC_W +: VAL_W];
    assign w_pos  = i_s_axis_tdata[FUNC_W + VAL_W +: POS_W];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_in_range = (CNT_W'(w_pos) < r_count);
    assign w_push_req = (w_func == F_PUSH_BACK) || (w_func == F_PUSH_FRONT);
    assign w_back_idx = IDX_W'(r_count - CNT_W'(1));

    always_comb begin
        n_status  = ST_OK;
        n_count   = r_count;
        w_rd_idx  = IDX_W'(w_pos);
        w_ok_read = 1'b0;
        case (w_func)
            F_PUSH_BACK, F_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            F_POP_BACK, F_POP_FRONT: begin
                w_rd_idx = (w_func == F_POP_BACK) ? w_back_idx : '0;
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ok_read = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            F_REMOVE_AT, F_READ_AT: begin
                if (!w_in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    w_ok_read = 1'b1;
                    if (w_func == F_REMOVE_AT) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign w_rd_data   = w_cell_q[w_rd_idx];
    assign w_back_data = w_cell_q[w_back_idx];
    assign n_value     = w_ok_read ? VAL_W'(w_rd_data) : '0;

    always_comb begin
        w_ctl.push_front = w_acc && (w_func == F_PUSH_FRONT) && !w_full;
        w_ctl.push_back  = w_acc && (w_func == F_PUSH_BACK) && !w_full;
        w_ctl.pull       = w_acc && (((w_func == F_POP_FRONT) && !w_empty)
                                  || ((w_func == F_REMOVE_AT) && w_in_range));
        w_ctl.count      = r_count;
        w_ctl.pos        = (w_func == F_POP_FRONT) ? '0 : IDX_W'(w_pos);
        w_ctl.value      = DATA_W'(w_val);
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_W-1:0] w_prev;
        logic [DATA_W-1:0] w_next;

        if (k == 0) begin : g_first
            assign w_prev = w_ctl.value;
        end else begin : g_mid_prev
            assign w_prev = w_cell_q[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign w_next = w_cell_q[k];
        end else begin : g_mid_next
            assign w_next = w_cell_q[k+1];
        end

        idq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_index (IDX_W'(k)),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_q     (w_cell_q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= n_status;
            r_value  <= n_value;
        end
    end

    // count, front and back are taken live from r_count and the row; these cannot
    // change while a result is pending
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {
        w_empty,
        w_empty ? VAL_W'(0) : VAL_W'(w_back_data),
        w_empty ? VAL_W'(0) : VAL_W'(w_cell_q[0]),
        OCNT_W'(r_count),
        r_value,
        r_status
    };

`include "assert_macros.svh"

    `AST_IMPLY(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH))
    `AST_NEXT(a_full_drop, w_acc && w_full && w_push_req, (r_status == ST_FULL) && w_full)
    `AST_NEXT(a_pop_count, w_ctl.pull && (w_func == F_POP_FRONT), r_count == $past(r_count) - CNT_W'(1))
    `AST_NEXT(a_bad_status_zero, w_acc && (n_status != ST_OK), r_value == '0)

endmodule

// File: dv/indexed_deque_top_test.sv
`timescale 1ns / 100ps

module indexed_deque_top_test;
    import idq_pkg::*;

    localparam logic [FUNC_W-1:0] F_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] F_SPARE_7 = 3'd7;

    localparam int N_RANDOM     = 1150;
    localparam int LONG_HOLD    = 300;
    localparam int LONG_HOLD_AT = 400;
    localparam int PAUSE_AT     = 600;
    localparam int TAIL_CYCLES  = 4;
    localparam int STALL_LIMIT  = 2000;
    localparam int N_DIRECTED   = 18;

    typedef struct packed {
        logic [S_DATA_W-FUNC_W-VAL_W-POS_W-1:0] pad;
        logic [POS_W-1:0]                       position;
        logic [VAL_W-1:0]                       value_in;
        logic [FUNC_W-1:0]                      func;
    } t_req;

    typedef struct packed {
        logic              is_empty;
        logic [VAL_W-1:0]  back_value;
        logic [VAL_W-1:0]  front_value;
        logic [OCNT_W-1:0] count;
        logic [VAL_W-1:0]  value_out;
        logic [STAT_W-1:0] status;
    } t_result;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [VAL_W-1:0]  value_in;
        logic [POS_W-1:0]  position;
        logic [4:0]        reps;
        logic              fixed;
        t_result           known;
    } t_step;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_MIXED, MIX_NOISE} t_mix;

    localparam t_result RES_POP_EMPTY = '{status: ST_EMPTY, value_out: '0, count: '0,
        front_value: '0, back_value: '0, is_empty: 1'b1};
    localparam t_result RES_RANGE_EMPTY = '{status: ST_RANGE, value_out: '0, count: '0,
        front_value: '0, back_value: '0, is_empty: 1'b1};
    localparam t_result RES_NOP_EMPTY = '{status: ST_OK, value_out: '0, count: '0,
        front_value: '0, back_value: '0, is_empty: 1'b1};
    localparam t_result RES_FIRST_ONES = '{status: ST_OK, value_out: '0, count: 5'd1,
        front_value: '1, back_value: '1, is_empty: 1'b0};

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    // func[2:0], value_in[34:3], position[38:35], zero pad
    logic [S_DATA_W-1:0] i_s_axis_tdata = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    // status[1:0], value_out[33:2], count[38:34], front_value[70:39],
    // back_value[102:71], is_empty[103]
    logic [M_DATA_W-1:0] o_m_axis_tdata;

    logic [VAL_W-1:0] deque_model[$];
    t_result          pending_results[$];
    t_step            dir_steps[N_DIRECTED];
    int               n_errors = 0;
    int               n_sent = 0;
    int               rx_cycle = 0;
    int               rx_stall_left = 0;
    int               rx_hold_left = 0;
    bit               rx_hold_done = 1'b0;

    indexed_deque_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the deque model by one request and return what the block must answer.
    task automatic apply_request(input t_req rq, output t_result res);
        int n;
        n = deque_model.size();
        res = '0;
        res.status = ST_OK;
        case (rq.func)
            F_PUSH_BACK: begin
                if (n >= DEPTH) res.status = ST_FULL;
                else deque_model.push_back(rq.value_in);
            end
            F_PUSH_FRONT: begin
                if (n >= DEPTH) res.status = ST_FULL;
                else deque_model.push_front(rq.value_in);
            end
            F_POP_BACK: begin
                if (n == 0) res.status = ST_EMPTY;
                else res.value_out = deque_model.pop_back();
            end
            F_POP_FRONT: begin
                if (n == 0) res.status = ST_EMPTY;
                else res.value_out = deque_model.pop_front();
            end
            F_REMOVE_AT: begin
                if (int'(rq.position) >= n) begin
                    res.status = ST_RANGE;
                end else begin
                    res.value_out = deque_model[rq.position];
                    deque_model.delete(int'(rq.position));
                end
            end
            F_READ_AT: begin
                if (int'(rq.position) >= n) res.status = ST_RANGE;
                else res.value_out = deque_model[rq.position];
            end
            default: ;
        endcase
        n = deque_model.size();
        res.count = OCNT_W'(n);
        res.is_empty = (n == 0);
        if (n > 0) begin
            res.front_value = deque_model[0];
            res.back_value = deque_model[n-1];
        end
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        return $urandom;
    endfunction

    function automatic t_req pick_request(input t_mix mix);
        t_req rq;
        int   n;
        int   r;
        n = deque_model.size();
        r = $urandom_range(0, 99);
        rq = '0;
        rq.value_in = pick_value();
        rq.position = POS_W'($urandom);
        case (mix)
            MIX_FILL:  rq.func = (r < 45) ? F_PUSH_BACK : (r < 85) ? F_PUSH_FRONT : F_READ_AT;
            MIX_DRAIN: rq.func = (r < 30) ? F_POP_BACK : (r < 55) ? F_POP_FRONT :
                                 (r < 85) ? F_REMOVE_AT : F_READ_AT;
            MIX_MIXED: rq.func = FUNC_W'($urandom_range(F_PUSH_BACK, F_READ_AT));
            default:   rq.func = FUNC_W'($urandom);
        endcase
        // keep most positions in range so removes actually shift entries
        if (mix != MIX_NOISE && n > 0 && r % 10 != 0)
            rq.position = POS_W'($urandom_range(0, n - 1));
        return rq;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Hold the request until the block takes it, then record what it must answer.
    task automatic offer(input t_req rq, input logic fixed, input t_result known);
        t_result res;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= rq;
        do @(posedge i_clk); while (!o_s_axis_tready);
        apply_request(rq, res);
        pending_results.push_back(fixed ? known : res);
        n_sent++;
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic compare_field(input string name, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (pending_results.size() == 0) begin
                $error("result transaction with no request outstanding");
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", VAL_W'(want.status), VAL_W'(got.status));
                compare_field("value_out", want.value_out, got.value_out);
                compare_field("count", VAL_W'(want.count), VAL_W'(got.count));
                compare_field("front_value", want.front_value, got.front_value);
                compare_field("back_value", want.back_value, got.back_value);
                compare_field("is_empty", VAL_W'(want.is_empty), VAL_W'(got.is_empty));
            end
        end
    end

    always @(posedge i_clk) begin
        int r;
        rx_cycle++;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (!rx_hold_done && n_sent >= LONG_HOLD_AT) begin
            // back up the block so its input stalls while requests keep coming
            rx_hold_done = 1'b1;
            rx_hold_left = LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if ((rx_cycle / 128) % 4 == 0) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                rx_stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(7, 39);
                i_m_axis_tready <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_req rq;
        t_mix mix;
        bit   quiet;
        bit   paused;
        int   seg_left;
        int   n_random;
        int   r;

        dir_steps = '{
            '{F_POP_BACK,   '0,            '0,    5'd1,  1'b1, RES_POP_EMPTY},
            '{F_POP_FRONT,  '0,            '0,    5'd1,  1'b1, RES_POP_EMPTY},
            '{F_REMOVE_AT,  '0,            4'd0,  5'd1,  1'b1, RES_RANGE_EMPTY},
            '{F_READ_AT,    '0,            4'd15, 5'd1,  1'b1, RES_RANGE_EMPTY},
            '{F_SPARE_7,    '1,            4'd15, 5'd1,  1'b1, RES_NOP_EMPTY},
            '{F_PUSH_BACK,  '1,            '0,    5'd1,  1'b1, RES_FIRST_ONES},
            '{F_PUSH_FRONT, '0,            '0,    5'd1,  1'b0, '0},
            '{F_READ_AT,    '0,            4'd1,  5'd1,  1'b0, '0},
            '{F_REMOVE_AT,  '0,            4'd0,  5'd1,  1'b0, '0},
            '{F_PUSH_BACK,  32'h1000_0000, '0,    5'd15, 1'b0, '0},
            '{F_PUSH_FRONT, 32'hA5A5_A5A5, '0,    5'd1,  1'b0, '0},
            '{F_READ_AT,    '0,            4'd15, 5'd1,  1'b0, '0},
            '{F_REMOVE_AT,  '0,            4'd15, 5'd1,  1'b0, '0},
            '{F_READ_AT,    '0,            4'd15, 5'd1,  1'b0, '0},
            '{F_REMOVE_AT,  '0,            4'd7,  5'd1,  1'b0, '0},
            '{F_POP_BACK,   '0,            '0,    5'd1,  1'b0, '0},
            '{F_POP_FRONT,  '0,            '0,    5'd1,  1'b0, '0},
            '{F_SPARE_6,    '1,            '0,    5'd1,  1'b0, '0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_steps[i]) begin
            for (int k = 0; k < dir_steps[i].reps; k++) begin
                rq = '0;
                rq.func = dir_steps[i].func;
                rq.value_in = dir_steps[i].value_in + VAL_W'(k);
                rq.position = dir_steps[i].position;
                offer(rq, dir_steps[i].fixed, dir_steps[i].known);
                idle_gap(pick_gap(1'b0));
            end
        end
        wait_all_results();

        n_random = 0;
        seg_left = 0;
        paused = 1'b0;
        mix = MIX_MIXED;
        quiet = 1'b0;
        while (n_random < N_RANDOM) begin
            if (seg_left == 0) begin
                r = $urandom_range(0, 99);
                mix = (r < 30) ? MIX_FILL : (r < 60) ? MIX_DRAIN : (r < 90) ? MIX_MIXED : MIX_NOISE;
                quiet = ($urandom_range(0, 3) == 0);
                seg_left = $urandom_range(8, 40);
            end
            seg_left--;
            rq = pick_request(mix);
            offer(rq, 1'b0, '0);
            if (rq.func != F_SPARE_6 && rq.func != F_SPARE_7)
                n_random++;
            if (!paused && n_random >= PAUSE_AT) begin
                paused = 1'b1;
                wait_all_results();
            end else begin
                idle_gap(pick_gap(quiet));
            end
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: indexed_deque_top.f
+incdir+rtl
rtl/idq_pkg.sv
rtl/idq_cell.sv
rtl/indexed_deque_top.sv
dv/indexed_deque_top_test.sv
